// ===== hdl/scfh_pkg.sv =====
// shared constants and byte update functions for the crc-32 / fnv-1a hasher
`default_nettype none
package scfh_pkg;

  localparam int unsigned HASH_W = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 2;

  localparam logic [APB_ADDR_W-1:0] ADDR_ALGORITHM = 2'd0;

  localparam logic ALG_CRC32 = 1'b0;
  localparam logic ALG_FNV1A = 1'b1;

  localparam logic [HASH_W-1:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [HASH_W-1:0] ALL_ONES  = 32'hFFFF_FFFF;
  localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

  // reflected crc-32, one bit per step
  function automatic logic [HASH_W-1:0] crc_byte(input logic [HASH_W-1:0] h,
                                                 input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      if (x[0]) begin
        x = (x >> 1) ^ CRC_POLY;
      end else begin
        x = x >> 1;
      end
    end
    return x;
  endfunction

  // fnv-1a: xor then multiply, modulo 2^32
  function automatic logic [HASH_W-1:0] fnv_byte(input logic [HASH_W-1:0] h,
                                                 input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] x;
    logic [HASH_W-1:0] p;
    x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
    p = x * FNV_PRIME;
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/scfh_channels.sv =====
// valid/ready channel interfaces for message bytes and finished hashes
`default_nettype none
interface scfh_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output byte_present,
                  output first_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input byte_present,
                input first_byte, input last_byte, output ready);
endinterface

interface scfh_hash_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink (input valid, input hash_value, output ready);
endinterface
`default_nettype wire

// ===== hdl/selectable_crc32_fnv1a_hasher_core.sv =====
// top level of the selectable crc-32 / fnv-1a 32 message hasher
//
// usage: bytes of a message arrive on the msg channel (valid/ready), one per
// request, marked first_byte and last_byte. a request with byte_present low
// carries no byte; marked first and last it hashes the empty message.
// the algorithm register (apb, address 0) picks crc-32 (0) or fnv-1a (1)
// and is to be written only while no request is in flight; the block does not enforce it.
// a finished hash leaves on the hash channel after the last byte.
// a request is registered in the input register, then hashed into the
// running hash and the result register; hash.valid rises when a last byte
// reaches the result register. throughput: one byte per cycle unless a
// message end waits for the result register; the crc bit loop and the fnv
// constant multiply both sit in the single stage between the two registers.
// reset: running hash returns to all ones, algorithm to crc-32, both
// channels empty.
// stall: while a finished hash waits, bytes that do not end a message keep
// flowing; a request that ends a message holds in the input register until
// the result register frees.
`default_nettype none
module selectable_crc32_fnv1a_hasher_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [scfh_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [scfh_pkg::APB_DATA_W-1:0] pwdata,
  output logic [scfh_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  scfh_msg_if.sink                        msg,
  scfh_hash_if.source                     hash
);
  import scfh_pkg::*;

  logic              algorithm;
  logic [HASH_W-1:0] running_hash;

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_data;
  logic              s1_present;
  logic              s1_first;
  logic              s1_last;

  logic              out_valid;
  logic [HASH_W-1:0] out_value;

  logic              out_free;
  logic              s1_go;
  logic [HASH_W-1:0] hash_next;
  logic [HASH_W-1:0] hash_final;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_ALGORITHM) ? {{(APB_DATA_W-1){1'b0}}, algorithm}
                                            : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      algorithm <= ALG_CRC32;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_ALGORITHM) begin
      algorithm <= pwdata[0];
    end
  end

  // handshake: only a message end needs room in the result register
  assign out_free  = !out_valid || hash.ready;
  assign s1_go     = s1_valid && (!s1_last || out_free);
  assign msg.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (msg.ready) begin
      s1_valid <= msg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.ready && msg.valid) begin
      s1_data    <= msg.data_byte;
      s1_present <= msg.byte_present;
      s1_first   <= msg.first_byte;
      s1_last    <= msg.last_byte;
    end
  end

  scfh_step u_step (
    .fnv          (algorithm == ALG_FNV1A),
    .running_hash (running_hash),
    .data_byte    (s1_data),
    .byte_present (s1_present),
    .first_byte   (s1_first),
    .hash_next    (hash_next),
    .hash_final   (hash_final)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= ALL_ONES;
    end else if (s1_go) begin
      running_hash <= hash_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (hash.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      out_value <= hash_final;
    end
  end

  assign hash.valid      = out_valid;
  assign hash.hash_value = out_value;

endmodule
`default_nettype wire

// ===== hdl/scfh_step.sv =====
// one byte of hash update plus the finishing xor for crc-32
`default_nettype none
module scfh_step (
  input  logic                        fnv,
  input  logic [scfh_pkg::HASH_W-1:0] running_hash,
  input  logic [scfh_pkg::BYTE_W-1:0] data_byte,
  input  logic                        byte_present,
  input  logic                        first_byte,
  output logic [scfh_pkg::HASH_W-1:0] hash_next,
  output logic [scfh_pkg::HASH_W-1:0] hash_final
);
  import scfh_pkg::*;

  logic [HASH_W-1:0] start;

  always_comb begin
    if (first_byte) begin
      start = fnv ? FNV_BASIS : ALL_ONES;
    end else begin
      start = running_hash;
    end

    if (!byte_present) begin
      hash_next = start;
    end else if (fnv) begin
      hash_next = fnv_byte(start, data_byte);
    end else begin
      hash_next = crc_byte(start, data_byte);
    end

    hash_final = fnv ? hash_next : (hash_next ^ ALL_ONES);
  end

endmodule
`default_nettype wire
